### hdl/uhcl_pkg.sv
// Package for the serial LED command block: result kinds, command codes,
// the action passed from the line editor to the frame emitter, and decode helpers.
// No dependencies.
package uhcl_pkg;

  // Line editor sizing.
  localparam int LINE_CAPACITY = 12;
  localparam int COUNT_W       = $clog2(LINE_CAPACITY + 1);
  localparam int IDX_W         = $clog2(LINE_CAPACITY);

  // Frame layout: four zero bytes, three four-byte LED frames, four 0xFF bytes.
  localparam int NUM_LEDS   = 3;
  localparam int FRAME_LEN  = 20;
  localparam int FIDX_W     = $clog2(FRAME_LEN);
  localparam logic [FIDX_W-1:0] FRAME_LAST = FIDX_W'(FRAME_LEN - 1);

  localparam logic [4:0] BRIGHT_RESET = 5'd10;
  localparam logic [7:0] LED_HDR      = 8'hE0;

  // Characters with special meaning.
  localparam logic [7:0] CH_BS   = 8'd8;
  localparam logic [7:0] CH_DEL  = 8'd127;
  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_6    = 8'h36;
  localparam logic [7:0] CH_8    = 8'h38;

  localparam int CMD_LEN     = 9;
  localparam int RAINBOW_LEN = 12;
  // "#FULLRAINBOW", first character at index 0.
  localparam logic [RAINBOW_LEN-1:0][7:0] RAINBOW_WORD = {
    8'h57, 8'h4F, 8'h42, 8'h4E, 8'h49, 8'h41,
    8'h52, 8'h4C, 8'h4C, 8'h55, 8'h46, 8'h23
  };

  // Result kinds as they leave the block.
  typedef enum logic [1:0] {
    KIND_LED   = 2'd0,
    KIND_ECHO  = 2'd1,
    KIND_ERASE = 2'd2,
    KIND_BAD   = 2'd3
  } kind_t;

  // What one input item asks of the emitter.
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_ONE   = 2'd1,
    ACT_FRAME = 2'd2
  } act_code_t;

  typedef logic [NUM_LEDS-1:0][23:0] rgb3_t;

  typedef struct packed {
    act_code_t   code;
    kind_t       kind;
    logic [7:0]  data;
    rgb3_t       colors;
  } action_t;

  // Hex digit decode: bit 4 marks a valid digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    begin
      v = 8'd0;
      if (c inside {[8'h30:8'h39]}) begin
        v = c - 8'h30;
        return {1'b1, v[3:0]};
      end else if (c inside {[8'h41:8'h46]}) begin
        v = c - 8'h37;
        return {1'b1, v[3:0]};
      end else if (c inside {[8'h61:8'h66]}) begin
        v = c - 8'h57;
        return {1'b1, v[3:0]};
      end
      return 5'd0;
    end
  endfunction

  // Color wheel, packed red<<16 | green<<8 | blue.
  function automatic logic [23:0] wheel_color(input logic [7:0] pos);
    logic [7:0] p;
    logic [7:0] q;
    logic [9:0] t;
    begin
      p = 8'd255 - pos;
      if (p < 8'd85) begin
        t = 10'(p) * 10'd3;
        return {8'd255 - t[7:0], 8'd0, t[7:0]};
      end else if (p < 8'd170) begin
        q = p - 8'd85;
        t = 10'(q) * 10'd3;
        return {8'd0, t[7:0], 8'd255 - t[7:0]};
      end
      q = p - 8'd170;
      t = 10'(q) * 10'd3;
      return {t[7:0], 8'd255 - t[7:0], 8'd0};
    end
  endfunction

  // One byte of the LED frame at position idx.
  function automatic logic [7:0] frame_byte(input logic [FIDX_W-1:0] idx,
                                            input rgb3_t colors,
                                            input logic [4:0] bright);
    logic [FIDX_W-1:0] sel;
    logic [23:0]       rgb;
    begin
      sel = idx - FIDX_W'(4);
      rgb = 24'd0;
      if (idx < FIDX_W'(4)) begin
        return 8'h00;
      end else if (idx >= FIDX_W'(FRAME_LEN - 4)) begin
        return 8'hFF;
      end
      case (sel[3:2])
        2'd0:    rgb = colors[0];
        2'd1:    rgb = colors[1];
        default: rgb = colors[2];
      endcase
      case (sel[1:0])
        2'd0:    return LED_HDR | {3'd0, bright};
        2'd1:    return rgb[7:0];
        2'd2:    return rgb[15:8];
        default: return rgb[23:16];
      endcase
    end
  endfunction

endpackage

### hdl/uhcl_cmd.sv
// Line editor and command parser: holds the line buffer, LED colors and
// rainbow state, and tells the emitter what each item produces. Uses uhcl_pkg.
module uhcl_cmd
  import uhcl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic       op,
  input  logic [7:0] rx_byte,
  output action_t    act
);

  logic [7:0]         line_buf [LINE_CAPACITY];
  logic [COUNT_W-1:0] char_count;
  rgb3_t              led_colors;
  logic               rainbow_on;
  logic [7:0]         wheel_position;

  logic               is_bs, is_eol, is_rainbow, cmd_ok, hex_ok;
  logic [23:0]        cmd_rgb;
  logic [4:0]         hv;
  logic [7:0]         led_sel;
  rgb3_t              colors_next;
  logic [7:0]         wheel_next;

  assign is_bs  = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
  assign is_eol = (rx_byte == CH_LF) || (rx_byte == CH_CR);

  // Parse the held line; entries at or beyond the count are masked by the length check.
  always_comb begin
    is_rainbow = (char_count == COUNT_W'(RAINBOW_LEN));
    for (int i = 0; i < RAINBOW_LEN; i++) begin
      if (line_buf[i] != RAINBOW_WORD[i]) is_rainbow = 1'b0;
    end
    hex_ok  = 1'b1;
    cmd_rgb = 24'd0;
    hv      = 5'd0;
    for (int i = 1; i <= 6; i++) begin
      hv      = hex_value(line_buf[i]);
      hex_ok  = hex_ok & hv[4];
      cmd_rgb = {cmd_rgb[19:0], hv[3:0]};
    end
    cmd_ok = (char_count == COUNT_W'(CMD_LEN)) && (line_buf[0] == CH_HASH) &&
             (line_buf[7] == CH_D) && (line_buf[8] >= CH_6) &&
             (line_buf[8] <= CH_8) && hex_ok;
    led_sel     = line_buf[8] - CH_6;
    colors_next = led_colors;
    case (led_sel[1:0])
      2'd0:    colors_next[0] = cmd_rgb;
      2'd1:    colors_next[1] = cmd_rgb;
      default: colors_next[2] = cmd_rgb;
    endcase
  end

  assign wheel_next = (wheel_position == 8'd254) ? 8'd0 : wheel_position + 8'd1;

  // Decide the results of the item at the input register.
  always_comb begin
    act.code   = ACT_NONE;
    act.kind   = KIND_LED;
    act.data   = 8'd0;
    act.colors = colors_next;
    if (op) begin
      act.colors = {NUM_LEDS{wheel_color(wheel_position)}};
      if (rainbow_on) act.code = ACT_FRAME;
    end else if (is_bs) begin
      if (char_count != '0) begin
        act.code = ACT_ONE;
        act.kind = KIND_ERASE;
      end
    end else if (is_eol) begin
      if (is_rainbow) begin
        act.code = ACT_NONE;
      end else if (cmd_ok) begin
        act.code = ACT_FRAME;
      end else begin
        act.code = ACT_ONE;
        act.kind = KIND_BAD;
      end
    end else if (char_count < COUNT_W'(LINE_CAPACITY)) begin
      act.code = ACT_ONE;
      act.kind = KIND_ECHO;
      act.data = rx_byte;
    end
  end

  // Control state. Any received byte clears rainbow mode; only the rainbow
  // command line turns it back on.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_count     <= '0;
      led_colors     <= '0;
      rainbow_on     <= 1'b0;
      wheel_position <= 8'd0;
    end else if (take) begin
      if (op) begin
        if (rainbow_on) wheel_position <= wheel_next;
      end else begin
        rainbow_on <= is_eol && is_rainbow;
        if (is_bs) begin
          if (char_count != '0) char_count <= char_count - COUNT_W'(1);
        end else if (is_eol) begin
          char_count <= '0;
          if (!is_rainbow && cmd_ok) begin
            led_colors <= colors_next;
          end
        end else if (char_count < COUNT_W'(LINE_CAPACITY)) begin
          char_count <= char_count + COUNT_W'(1);
        end
      end
    end
  end

  // Line buffer, written at the fill position.
  always_ff @(posedge clk) begin
    if (take && !op && !is_bs && !is_eol && (char_count < COUNT_W'(LINE_CAPACITY))) begin
      line_buf[char_count[IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

### hdl/uart_hex_color_command_led_driver.sv
// Top level of the serial LED command block: input register, frame emitter
// and output register. Uses uhcl_pkg and uhcl_cmd.
//
//  channel | signals                         | content
//  --------+---------------------------------+--------------------------------------
//  in      | s_tvalid s_tready s_tdata s_tuser | rx_byte in tdata, operation in tuser
//  out     | m_tvalid m_tready m_tdata m_tuser m_tlast | data, kind, last
//  config  | cfg_we cfg_wdata                | global_brightness
//
// Items that give one result or none flow back to back at one per cycle while the
// output is not stalled. A command or rainbow frame holds the input until its 20
// frame bytes, one per output transfer, have left the single output register.
// Reset clears all control state; brightness returns to 10.
// A stalled output holds its byte; the input register still takes one item meanwhile.
module uart_hex_color_command_led_driver
  import uhcl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  input  logic       s_tuser,   // [0] operation
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] data
  output logic [1:0] m_tuser,   // [1:0] kind
  output logic       m_tlast,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);

  logic              in_valid;
  logic              in_op;
  logic [7:0]        in_byte;
  logic              in_take;
  logic              out_free;
  logic              busy;
  logic [FIDX_W-1:0] fidx;
  rgb3_t             frame_colors;
  logic [4:0]        bright;
  action_t           act;

  uhcl_cmd u_cmd (
    .clk     (clk),
    .rst     (rst),
    .take    (in_take),
    .op      (in_op),
    .rx_byte (in_byte),
    .act     (act)
  );

  assign out_free = !m_tvalid || m_tready;
  assign in_take  = in_valid && out_free && !busy;
  assign s_tready = !in_valid || in_take;

  // Brightness register.
  always_ff @(posedge clk) begin
    if (rst) begin
      bright <= BRIGHT_RESET;
    end else if (cfg_we) begin
      bright <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  // Frame emitter and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      busy     <= 1'b0;
      fidx     <= '0;
    end else if (out_free) begin
      if (busy) begin
        m_tvalid <= 1'b1;
        m_tuser  <= KIND_LED;
        m_tdata  <= frame_byte(fidx, frame_colors, bright);
        m_tlast  <= (fidx == FRAME_LAST);
        busy     <= (fidx != FRAME_LAST);
        fidx     <= fidx + FIDX_W'(1);
      end else if (in_take && act.code == ACT_FRAME) begin
        m_tvalid     <= 1'b1;
        m_tuser      <= KIND_LED;
        m_tdata      <= frame_byte('0, act.colors, bright);
        m_tlast      <= 1'b0;
        busy         <= 1'b1;
        fidx         <= FIDX_W'(1);
        frame_colors <= act.colors;
      end else if (in_take && act.code == ACT_ONE) begin
        m_tvalid <= 1'b1;
        m_tuser  <= act.kind;
        m_tdata  <= act.data;
        m_tlast  <= 1'b1;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // A frame in progress always has a byte waiting at the output.
  a_busy_valid: assert property (@(posedge clk) disable iff (rst) busy |-> m_tvalid)
    else $error("frame in progress without output byte");

  // The frame index stays inside the frame while busy.
  a_fidx_range: assert property (@(posedge clk) disable iff (rst)
      busy |-> (fidx != '0) && (fidx <= FRAME_LAST))
    else $error("frame index out of range");

  // Emitting the final frame byte ends the frame.
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
      (busy && out_free && fidx == FRAME_LAST) |=> !busy && m_tlast)
    else $error("frame did not end after its last byte");

  // Single results always close their item.
  a_single_last: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && m_tuser != KIND_LED) |-> m_tlast)
    else $error("single result without last");

  // Erase and bad input carry zero data.
  a_zero_data: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && (m_tuser == KIND_ERASE || m_tuser == KIND_BAD)) |-> m_tdata == 8'd0)
    else $error("nonzero data on erase or bad input");

endmodule
